// ===== design/wnws_pkg.sv =====
// Shared types, widths and request codes for the windowed nearest waypoint search.
// No dependencies; every other design file imports this package.

package wnws_pkg;

    // Table geometry and search window
    localparam int MAP_DEPTH     = 4096;
    localparam int SEARCH_WINDOW = 32;
    localparam int IDX_W         = $clog2(MAP_DEPTH);
    localparam int CNT_W         = IDX_W + 1;

    // Coordinate and distance widths (Q15.8 coordinates)
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIFF_W - 1;
    localparam int DIST_W  = SQ_W + 1;

    // Latency of the shared squaring unit, start to done
    localparam int DIST_LAT = 4;

    // Look-ahead register and reported index
    localparam int LA_W      = 12;
    localparam int OUT_IDX_W = 12;
    localparam logic [LA_W-1:0] LOOK_AHEAD_RST = LA_W'(10);

    // Adder widths for the window end and the target index
    localparam int WIN_BITS = $clog2(SEARCH_WINDOW + 1);
    localparam int WSUM_W   = ((IDX_W > WIN_BITS) ? IDX_W : WIN_BITS) + 1;
    localparam int TSUM_W   = ((IDX_W > LA_W) ? IDX_W : LA_W) + 1;

    // Request type codes
    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

endpackage

// ===== design/wnws_if.sv =====
// Request and result channel interfaces (valid/ready with payload).
// Depends on wnws_pkg for field widths.

interface wnws_req_if;
    import wnws_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;

    modport source (output valid, output req_type, output point_x, output point_y,
                    input ready);
    modport sink   (input valid, input req_type, input point_x, input point_y,
                    output ready);
endinterface

interface wnws_res_if;
    import wnws_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      map_valid;
    logic [OUT_IDX_W-1:0]      closest_index;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;

    modport source (output valid, output map_valid, output closest_index,
                    output target_x, output target_y, input ready);
    modport sink   (input valid, input map_valid, input closest_index,
                    input target_x, input target_y, output ready);
endinterface

// ===== design/wnws_store.sv =====
// Waypoint table: one write port, one read port with registered read data.
// Depends on wnws_pkg for the point type and table depth.

module wnws_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [wnws_pkg::IDX_W-1:0]  i_waddr,
    input  wnws_pkg::t_point            i_wdata,
    input  logic                        i_re,
    input  logic [wnws_pkg::IDX_W-1:0]  i_raddr,
    output wnws_pkg::t_point            o_rdata
);
    import wnws_pkg::*;

    t_point r_mem [MAP_DEPTH];
    t_point r_rdata;

    // Write on append, read under sequencer control
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/wnws_dist.sv =====
// Squared distance unit: one shared 25x25 multiplier squares dx then dy.
// Depends on wnws_pkg; o_done rises when the stage marker reaches its top bit.

module wnws_dist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  wnws_pkg::t_point            i_wp,
    input  wnws_pkg::t_point            i_pos,
    output logic                        o_done,
    output logic [wnws_pkg::DIST_W-1:0] o_dist
);
    import wnws_pkg::*;

    logic [DIST_LAT-1:0]       r_stage, n_stage;
    logic signed [DIFF_W-1:0]  r_diff, n_diff;
    logic signed [2*DIFF_W-1:0] w_prod;
    logic [SQ_W-1:0]           r_sq;
    logic [DIST_W-1:0]         r_acc, n_acc;

    // Advance the stage marker; pick dx on start, dy in the following cycle
    always_comb begin
        n_stage = {r_stage[DIST_LAT-2:0], i_start};
        if (r_stage[0]) begin
            n_diff = $signed({i_wp.y[COORD_W-1], i_wp.y})
                   - $signed({i_pos.y[COORD_W-1], i_pos.y});
        end else begin
            n_diff = $signed({i_wp.x[COORD_W-1], i_wp.x})
                   - $signed({i_pos.x[COORD_W-1], i_pos.x});
        end
    end

    // Shared squarer
    assign w_prod = r_diff * r_diff;

    // Load dx squared, then add dy squared
    always_comb begin
        if (r_stage[1]) begin
            n_acc = DIST_W'(r_sq);
        end else if (r_stage[2]) begin
            n_acc = r_acc + DIST_W'(r_sq);
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= n_diff;
        r_sq   <= w_prod[SQ_W-1:0];
        r_acc  <= n_acc;
    end

    assign o_done = r_stage[DIST_LAT-1];
    assign o_dist = r_acc;

endmodule

// ===== design/windowed_nearest_waypoint_search.sv =====
// Top level: request decode, search sequencer, look-ahead register, result register.
// Depends on wnws_pkg, wnws_if, wnws_store and wnws_dist.
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    req_type, point_x, point_y
//  o_res     out  valid/ready    map_valid, closest_index, target_x, target_y
//  i_cfg_*   in   write enable   look_ahead (12 bits)
//
// Clear and append take effect on acceptance. A query covers n = 1 .. SEARCH_WINDOW+1
// points; each point costs one table read plus two passes through the one shared
// squarer. An empty-table query goes straight from S_IDLE to S_OUT.
// Reset is synchronous, active low; it empties the table and sets look_ahead to 10.
// A finished result waits in the output register; a new request is taken meanwhile
// unless a query finishes while the previous result is still held.

module windowed_nearest_waypoint_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    wnws_req_if.sink                   i_req,
    wnws_res_if.source                 o_res,
    input  logic                       i_cfg_we,
    input  logic [wnws_pkg::LA_W-1:0]  i_cfg_wdata
);
    import wnws_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_INIT = 9'b000000010,
        S_WIN  = 9'b000000100,
        S_RD   = 9'b000001000,
        S_GO   = 9'b000010000,
        S_WAIT = 9'b000100000,
        S_TGT  = 9'b001000000,
        S_TRD  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_last_nearest;
    logic [LA_W-1:0]       r_look_ahead;
    t_point                r_pos;
    logic [IDX_W-1:0]      r_last;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_end;
    logic [IDX_W-1:0]      r_best;
    logic [DIST_W-1:0]     r_best_d;
    logic                  r_first;
    logic                  r_empty;
    logic [IDX_W-1:0]      r_tgt;

    logic                  r_res_valid;
    logic                  r_res_map_valid;
    logic [OUT_IDX_W-1:0]  r_res_index;
    logic signed [COORD_W-1:0] r_res_x;
    logic signed [COORD_W-1:0] r_res_y;

    logic                  w_req_fire;
    logic                  w_res_free;
    logic                  w_we;
    t_point                w_wdata;
    logic                  w_rd_en;
    logic [IDX_W-1:0]      w_rd_addr;
    t_point                w_rdata;
    logic                  w_dist_start;
    logic                  w_dist_done;
    logic [DIST_W-1:0]     w_dist;
    logic [IDX_W-1:0]      w_last;
    logic [WSUM_W-1:0]     w_win_sum;
    logic [TSUM_W-1:0]     w_tgt_sum;
    logic                  w_better;

    // Handshake
    assign i_req.ready = (r_state == S_IDLE);
    assign w_req_fire  = i_req.valid && i_req.ready;
    assign w_res_free  = !r_res_valid || o_res.ready;

    // Table write on append while room is left
    assign w_we = w_req_fire && (i_req.req_type == REQ_APPEND)
               && (r_count < CNT_W'(MAP_DEPTH));
    assign w_wdata.x = i_req.point_x;
    assign w_wdata.y = i_req.point_y;

    // Table read: search points, then the target
    assign w_rd_en   = (r_state == S_RD) || (r_state == S_TRD);
    assign w_rd_addr = (r_state == S_TRD) ? r_tgt : r_idx;

    wnws_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    assign w_dist_start = (r_state == S_GO);

    wnws_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dist_start),
        .i_wp    (w_rdata),
        .i_pos   (r_pos),
        .o_done  (w_dist_done),
        .o_dist  (w_dist)
    );

    // Index arithmetic
    assign w_last    = IDX_W'(r_count - CNT_W'(1));
    assign w_win_sum = WSUM_W'(r_idx) + WSUM_W'(SEARCH_WINDOW);
    assign w_tgt_sum = TSUM_W'(r_best) + TSUM_W'(r_look_ahead);
    assign w_better  = r_first || (w_dist < r_best_d);

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_fire && (i_req.req_type == REQ_QUERY)) begin
                    n_state = (r_count == '0) ? S_OUT : S_INIT;
                end
            end
            S_INIT: n_state = S_WIN;
            S_WIN:  n_state = S_RD;
            S_RD:   n_state = S_GO;
            S_GO:   n_state = S_WAIT;
            S_WAIT: begin
                if (w_dist_done) begin
                    n_state = (r_idx == r_end) ? S_TGT : S_RD;
                end
            end
            S_TGT:  n_state = S_TRD;
            S_TRD:  n_state = S_OUT;
            S_OUT: begin
                if (w_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state: sequencer, fill count, closest index, look-ahead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_last_nearest <= '0;
            r_look_ahead   <= LOOK_AHEAD_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_look_ahead <= i_cfg_wdata;
            end
            if (w_req_fire && (i_req.req_type == REQ_CLEAR)) begin
                r_count        <= '0;
                r_last_nearest <= '0;
            end
            if (w_we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (r_state == S_TGT) begin
                r_last_nearest <= r_best;
            end
        end
    end

    // Search datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_pos.x <= i_req.point_x;
                r_pos.y <= i_req.point_y;
                r_last  <= w_last;
                r_empty <= (r_count == '0);
            end
            S_INIT: begin
                // Clamp a stale closest index to the last stored point
                if (r_last_nearest > r_last) begin
                    r_idx  <= r_last;
                    r_best <= r_last;
                end else begin
                    r_idx  <= r_last_nearest;
                    r_best <= r_last_nearest;
                end
                r_first <= 1'b1;
            end
            S_WIN: begin
                if (w_win_sum > WSUM_W'(r_last)) begin
                    r_end <= r_last;
                end else begin
                    r_end <= IDX_W'(w_win_sum);
                end
            end
            S_WAIT: begin
                if (w_dist_done) begin
                    // Strict less-than keeps the earlier point on a tie
                    if (w_better) begin
                        r_best_d <= w_dist;
                        r_best   <= r_idx;
                    end
                    r_first <= 1'b0;
                    if (r_idx != r_end) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
            end
            S_TGT: begin
                if (w_tgt_sum > TSUM_W'(r_last)) begin
                    r_tgt <= r_last;
                end else begin
                    r_tgt <= IDX_W'(w_tgt_sum);
                end
            end
            default: begin
            end
        endcase
    end

    // Result register: hold until taken, load when a query completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_res_free) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_res_free) begin
            r_res_map_valid <= !r_empty;
            if (r_empty) begin
                r_res_index <= '0;
                r_res_x     <= '0;
                r_res_y     <= '0;
            end else begin
                r_res_index <= OUT_IDX_W'(r_best);
                r_res_x     <= w_rdata.x;
                r_res_y     <= w_rdata.y;
            end
        end
    end

    assign o_res.valid         = r_res_valid;
    assign o_res.map_valid     = r_res_map_valid;
    assign o_res.closest_index = r_res_index;
    assign o_res.target_x      = r_res_x;
    assign o_res.target_y      = r_res_y;

`ifndef SYNTHESIS
    a_dist_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dist_start |-> ##4 w_dist_done)
        else $error("squared distance not ready after fixed latency");

    a_window_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ((r_idx <= r_end) && (r_end <= r_last)))
        else $error("search index outside window or past last point");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAP_DEPTH))
        else $error("fill count beyond table depth");

    a_best_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TGT) |=> (r_last_nearest <= r_last) && (r_tgt <= r_last))
        else $error("closest or target index past last stored point");
`endif

endmodule

// ===== bench/wnws_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the windowed nearest waypoint search: watches the request,
// result and look-ahead write ports, predicts every query result and compares.
// Depends on wnws_pkg and the channel interfaces of wnws_if.

module wnws_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    wnws_req_if                       i_req,
    wnws_res_if                       i_res,
    input  logic                      i_cfg_we,
    input  logic [wnws_pkg::LA_W-1:0] i_cfg_wdata,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_req_seen,
    output int                        o_res_seen
);
    import wnws_pkg::*;

    localparam int DIST_BITS = 2 * COORD_W + 2;

    typedef struct packed {
        logic                      map_valid;
        logic [OUT_IDX_W-1:0]      closest_index;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
    } t_search_result;

    // Own copy of the waypoint table and search state
    logic signed [COORD_W-1:0] wp_x [MAP_DEPTH];
    logic signed [COORD_W-1:0] wp_y [MAP_DEPTH];
    logic [CNT_W-1:0]          wp_count;
    logic [IDX_W-1:0]          nearest_idx;
    logic [LA_W-1:0]           look_ahead;

    t_search_result due_results [$];
    int fail_count;
    int pending_cnt;
    int req_seen;
    int res_seen;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;
    assign o_req_seen   = req_seen;
    assign o_res_seen   = res_seen;

    initial begin
        fail_count  = 0;
        pending_cnt = 0;
        req_seen    = 0;
        res_seen    = 0;
    end

    // Exact squared distance from stored point idx to the vehicle
    function automatic logic [DIST_BITS-1:0] sq_dist(int idx,
                                                     logic signed [COORD_W-1:0] px,
                                                     logic signed [COORD_W-1:0] py);
        longint dx;
        longint dy;
        dx = longint'(wp_x[idx]) - longint'(px);
        dy = longint'(wp_y[idx]) - longint'(py);
        return DIST_BITS'(dx * dx + dy * dy);
    endfunction

    // Forward window search; updates the nearest index and picks the target
    function automatic t_search_result search_nearest(logic signed [COORD_W-1:0] px,
                                                      logic signed [COORD_W-1:0] py);
        t_search_result     r;
        int                 last;
        int                 best;
        int                 stop;
        int                 tgt;
        int                 i;
        logic [DIST_BITS-1:0] best_d;
        logic [DIST_BITS-1:0] d;
        r = '0;
        if (wp_count == 0)
            return r;
        last = int'(wp_count) - 1;
        if (int'(nearest_idx) > last)
            nearest_idx = IDX_W'(last);
        best   = int'(nearest_idx);
        best_d = sq_dist(best, px, py);
        stop   = best + SEARCH_WINDOW;
        if (stop > last)
            stop = last;
        for (i = int'(nearest_idx) + 1; i <= stop; i++) begin
            d = sq_dist(i, px, py);
            // strict compare keeps the earlier point on a tie
            if (d < best_d) begin
                best_d = d;
                best   = i;
            end
        end
        nearest_idx = IDX_W'(best);
        tgt = best + int'(look_ahead);
        if (tgt > last)
            tgt = last;
        r.map_valid     = 1'b1;
        r.closest_index = OUT_IDX_W'(best);
        r.target_x      = wp_x[tgt];
        r.target_y      = wp_y[tgt];
        return r;
    endfunction

    function automatic void check_field(string name, logic [COORD_W-1:0] want,
                                        logic [COORD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            fail_count++;
        end
    endfunction

    // Compare results, follow look-ahead writes, predict each request
    always @(posedge i_clk) begin : watch
        t_search_result want;
        t_search_result got;
        if (!i_rst_n) begin
            wp_count    = '0;
            nearest_idx = '0;
            look_ahead  = LOOK_AHEAD_RST;
            due_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                res_seen++;
                got.map_valid     = i_res.map_valid;
                got.closest_index = i_res.closest_index;
                got.target_x      = i_res.target_x;
                got.target_y      = i_res.target_y;
                if (due_results.size() == 0) begin
                    $error("result with nothing outstanding: closest_index %0d",
                           got.closest_index);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("map_valid", COORD_W'(want.map_valid),
                                COORD_W'(got.map_valid));
                    check_field("closest_index", COORD_W'(want.closest_index),
                                COORD_W'(got.closest_index));
                    check_field("target_x", want.target_x, got.target_x);
                    check_field("target_y", want.target_y, got.target_y);
                end
            end
            if (i_cfg_we)
                look_ahead = i_cfg_wdata;
            if (i_req.valid && i_req.ready) begin
                req_seen++;
                case (i_req.req_type)
                    REQ_CLEAR: begin
                        wp_count    = '0;
                        nearest_idx = '0;
                    end
                    REQ_APPEND: begin
                        // drop appends once the table is full
                        if (wp_count < CNT_W'(MAP_DEPTH)) begin
                            wp_x[wp_count] = i_req.point_x;
                            wp_y[wp_count] = i_req.point_y;
                            wp_count++;
                        end
                    end
                    REQ_QUERY: begin
                        due_results.push_back(search_nearest(i_req.point_x,
                                                             i_req.point_y));
                    end
                    default: ;
                endcase
            end
        end
        pending_cnt = due_results.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the waypoint search bench: clock, reset, request and result traffic,
// look-ahead writes and the verdict. Depends on wnws_pkg, wnws_if, the block
// and wnws_checker.

module tb_top;
    import wnws_pkg::*;

    localparam int SETTLE_CYCLES = 220;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int STALL_CYCLES  = 400;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic            i_clk;
    logic            i_rst_n;
    logic            cfg_we;
    logic [LA_W-1:0] cfg_wdata;

    wnws_req_if req_ch ();
    wnws_res_if res_ch ();

    int fail_count;
    int pending;
    int req_seen;
    int res_seen;

    int src_idle_pct;
    int sink_idle_pct;
    bit hold_request;
    int cycles;
    int items_sent;

    // Stimulus-side record of the path, used to aim queries along it
    logic signed [COORD_W-1:0] path_x [MAP_DEPTH];
    logic signed [COORD_W-1:0] path_y [MAP_DEPTH];
    int path_len;
    int cursor;

    windowed_nearest_waypoint_search u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    wnws_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_req_seen   (req_seen),
        .o_res_seen   (res_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Give up once the cycle budget is spent
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Result side: random back-pressure, with one long hold on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom);
    endfunction

    function automatic logic signed [COORD_W-1:0] jitter(int span);
        return COORD_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    // Offer one request, idling at random first; track the path on acceptance
    task automatic send_req(logic [REQ_W-1:0] kind, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.point_x  <= x;
        req_ch.point_y  <= y;
        do @(posedge i_clk); while (!req_ch.ready);
        if (kind != REQ_UNUSED)
            items_sent++;
        if (kind == REQ_CLEAR) begin
            path_len = 0;
            cursor   = 0;
        end else if (kind == REQ_APPEND && path_len < MAP_DEPTH) begin
            path_x[path_len] = x;
            path_y[path_len] = y;
            path_len++;
        end
    endtask

    // Drop valid, wait for every result, then let the block go quiet
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_look_ahead(logic [LA_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Append a roughly straight run of points; step size picks the density
    task automatic build_path(int n);
        int bx;
        int by;
        int sx;
        int sy;
        int mag;
        int i;
        bx = int'($urandom);
        by = int'($urandom);
        case ($urandom_range(3))
            0: mag = 0;
            1: mag = 4;
            2: mag = 300;
            default: mag = 40000;
        endcase
        sx = int'($urandom_range(2 * mag)) - mag;
        sy = int'($urandom_range(2 * mag)) - mag;
        for (i = 0; i < n; i++) begin
            send_req(REQ_APPEND, COORD_W'(bx + i * sx) + jitter(mag / 8),
                     COORD_W'(by + i * sy) + jitter(mag / 8));
        end
    endtask

    // Queries near points along the path, mostly ahead, a few behind or anywhere
    task automatic walk_queries(int k);
        int pick;
        int aim;
        repeat (k) begin
            pick = $urandom_range(9);
            if (path_len == 0 || pick == 0) begin
                send_req(REQ_QUERY, rand_coord(), rand_coord());
            end else begin
                aim = cursor + int'($urandom_range(36));
                if (pick == 1)
                    aim -= int'($urandom_range(44));
                if (aim < 0)
                    aim = 0;
                if (aim > path_len - 1)
                    aim = path_len - 1;
                send_req(REQ_QUERY, path_x[aim] + jitter(4), path_y[aim] + jitter(4));
                if (aim > cursor)
                    cursor = aim;
            end
        end
    endtask

    // Random traffic: paths, query walks, clears and noise; two look-ahead values
    task automatic run_random(int n, logic [LA_W-1:0] la_first, logic [LA_W-1:0] la_second);
        int goal;
        int half;
        int sel;
        bit switched;
        write_look_ahead(la_first);
        goal     = items_sent + n;
        half     = items_sent + n / 2;
        switched = 1'b0;
        while (items_sent < goal) begin
            if (!switched && items_sent >= half) begin
                write_look_ahead(la_second);
                switched = 1'b1;
            end
            sel = $urandom_range(99);
            if (sel < 8)
                send_req(REQ_W'($urandom_range(3)), rand_coord(), rand_coord());
            else if (sel < 13)
                send_req(REQ_CLEAR, rand_coord(), rand_coord());
            else if (sel < 45)
                build_path(($urandom_range(9) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(24));
            else
                walk_queries($urandom_range(1, 10));
        end
    endtask

    // Extremes, ties, empty table, forward-only search and ignored requests
    task automatic run_directed();
        send_req(REQ_QUERY, '0, '0);
        send_req(REQ_UNUSED, COORD_MAX, COORD_MIN);
        send_req(REQ_APPEND, COORD_MAX, COORD_MAX);
        send_req(REQ_QUERY, COORD_MIN, COORD_MIN);
        send_req(REQ_APPEND, COORD_MIN, COORD_MIN);
        send_req(REQ_APPEND, '0, '0);
        send_req(REQ_APPEND, COORD_MAX, COORD_MIN);
        send_req(REQ_APPEND, COORD_MIN, COORD_MAX);
        send_req(REQ_APPEND, '0, '0);
        send_req(REQ_QUERY, COORD_MIN, COORD_MIN);
        send_req(REQ_QUERY, '0, '0);
        send_req(REQ_QUERY, COORD_MAX, COORD_MAX);
        send_req(REQ_QUERY, COORD_W'(1), -COORD_W'(1));
        send_req(REQ_CLEAR, COORD_MAX, COORD_MAX);
        send_req(REQ_QUERY, COORD_MAX, COORD_MIN);
        send_req(REQ_APPEND, -COORD_W'(1), -COORD_W'(1));
        send_req(REQ_APPEND, COORD_W'(1), COORD_W'(1));
        send_req(REQ_QUERY, '0, '0);
        send_req(REQ_UNUSED, '0, '0);
        send_req(REQ_APPEND, -COORD_W'(1), COORD_W'(1));
        send_req(REQ_QUERY, -COORD_W'(256), COORD_W'(256));
        send_req(REQ_CLEAR, '0, '0);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_CLEAR;
        req_ch.point_x  <= '0;
        req_ch.point_y  <= '0;
        hold_request     = 1'b0;
        items_sent       = 0;
        path_len         = 0;
        cursor           = 0;
        src_idle_pct     = 32;
        sink_idle_pct    = 51;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset look-ahead value stays in force for the directed part
        run_directed();
        run_random(600, '0, LA_W'(1));

        src_idle_pct  = 51;
        sink_idle_pct = 32;
        run_random(600, '1, LA_W'($urandom_range(2, 40)));

        // no idling; hold the result side off while queries keep coming
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_look_ahead(LA_W'($urandom_range(3, 60)));
        send_req(REQ_CLEAR, rand_coord(), rand_coord());
        build_path(40);
        hold_request = 1'b1;
        walk_queries(20);
        run_random(380, LA_W'($urandom_range(0, 4095)), LA_W'($urandom_range(5, 20)));

        settle();

        $display("Checked %0d results from %0d accepted requests over look-ahead 0 to 4095,",
                 res_seen, req_seen);
        $display("with empty tables, ties, backward queries and a long result stall.");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
